>>> hw/rtl/tfv_pkg.sv
`default_nettype none

package tfv_pkg;

    localparam int TEMP_WIDTH  = 12;
    localparam int DUTY_WIDTH  = 8;
    localparam int HYST_WIDTH  = 8;
    localparam int CFG_IDX_WIDTH  = 4;
    localparam int CFG_DATA_WIDTH = (TEMP_WIDTH > DUTY_WIDTH) ? TEMP_WIDTH : DUTY_WIDTH;
    // Wide enough that setpoint +/- hysteresis never wraps.
    localparam int BAND_WIDTH  = ((TEMP_WIDTH > HYST_WIDTH + 1) ? TEMP_WIDTH : HYST_WIDTH + 1) + 1;

    localparam logic [TEMP_WIDTH-1:0] SETPOINT_RESET   = TEMP_WIDTH'(220);
    localparam logic [HYST_WIDTH-1:0] HYSTERESIS_RESET = HYST_WIDTH'(5);
    localparam logic [DUTY_WIDTH-1:0] PELTIER_RESET    = DUTY_WIDTH'(255);
    localparam logic [DUTY_WIDTH-1:0] FAN_RESET        = DUTY_WIDTH'(255);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_SETPOINT      = CFG_IDX_WIDTH'(0),
        CFG_HYSTERESIS    = CFG_IDX_WIDTH'(1),
        CFG_PELTIER_LEVEL = CFG_IDX_WIDTH'(2),
        CFG_FAN_LEVEL     = CFG_IDX_WIDTH'(3)
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_HEAT  = 3'd1,
        MODE_COOL  = 3'd2,
        MODE_FHEAT = 3'd3,
        MODE_FCOOL = 3'd4
    } mode_t;

    typedef struct packed {
        logic signed [TEMP_WIDTH-1:0] setpoint;
        logic        [HYST_WIDTH-1:0] hysteresis;
        logic        [DUTY_WIDTH-1:0] peltier_level;
        logic        [DUTY_WIDTH-1:0] fan_level;
    } tfv_cfg_t;

    typedef struct packed {
        logic signed [TEMP_WIDTH-1:0] inside_temp;
        logic signed [TEMP_WIDTH-1:0] outside_temp;
        logic                         outside_ok;
        logic                         air_quality_vent;
        logic                         humidity_vent;
    } tfv_in_t;

    typedef struct packed {
        mode_t                  mode;
        logic [DUTY_WIDTH-1:0]  peltier_duty;
        logic [DUTY_WIDTH-1:0]  fan_duty;
        logic                   heat_polarity;
        logic                   heat_relay_on;
        logic                   cool_relay_on;
        logic                   flap_is_open;
        logic                   free_vent_active;
        logic                   override_active;
    } tfv_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/tfv_cfg.sv
`default_nettype none

module tfv_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 wr_en,
    input  wire logic [tfv_pkg::CFG_IDX_WIDTH-1:0]    wr_index,
    input  wire logic [tfv_pkg::CFG_DATA_WIDTH-1:0]   wr_data,
    output tfv_pkg::tfv_cfg_t                         cfg
);
    import tfv_pkg::*;

    tfv_cfg_t cfg_reg;
    tfv_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_index_t'(wr_index))
                CFG_SETPOINT:      cfg_next.setpoint      = wr_data[TEMP_WIDTH-1:0];
                CFG_HYSTERESIS:    cfg_next.hysteresis    = wr_data[HYST_WIDTH-1:0];
                CFG_PELTIER_LEVEL: cfg_next.peltier_level = wr_data[DUTY_WIDTH-1:0];
                CFG_FAN_LEVEL:     cfg_next.fan_level     = wr_data[DUTY_WIDTH-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint      <= SETPOINT_RESET;
            cfg_reg.hysteresis    <= HYSTERESIS_RESET;
            cfg_reg.peltier_level <= PELTIER_RESET;
            cfg_reg.fan_level     <= FAN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tfv_ctrl.sv
`default_nettype none

module tfv_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire tfv_pkg::tfv_in_t  item,
    input  wire tfv_pkg::tfv_cfg_t cfg,
    output tfv_pkg::tfv_out_t result
);
    import tfv_pkg::*;

    mode_t                 mode_reg,     mode_next;
    logic                  prev_ovr_reg, prev_ovr_next;
    logic                  flap_reg,     flap_next;
    logic                  vent_reg,     vent_next;
    logic [DUTY_WIDTH-1:0] peltier_reg,  peltier_next;
    logic [DUTY_WIDTH-1:0] fan_reg,      fan_next;
    logic                  pol_reg,      pol_next;
    logic [1:0]            relay_reg,    relay_next;

    logic                        ovr;
    logic signed [BAND_WIDTH-1:0] inside_w;
    logic signed [BAND_WIDTH-1:0] band_lo;
    logic signed [BAND_WIDTH-1:0] band_hi;
    logic                        in_ge_sp, in_le_sp, out_gt_sp, out_lt_sp;
    logic                        out_ge_in, out_le_in;

    assign ovr      = item.air_quality_vent | item.humidity_vent;
    assign inside_w = BAND_WIDTH'(item.inside_temp);
    assign band_lo  = BAND_WIDTH'(cfg.setpoint) - $signed(BAND_WIDTH'(cfg.hysteresis));
    assign band_hi  = BAND_WIDTH'(cfg.setpoint) + $signed(BAND_WIDTH'(cfg.hysteresis));

    assign in_ge_sp  = item.inside_temp  >= cfg.setpoint;
    assign in_le_sp  = item.inside_temp  <= cfg.setpoint;
    assign out_gt_sp = item.outside_temp >  cfg.setpoint;
    assign out_lt_sp = item.outside_temp <  cfg.setpoint;
    assign out_ge_in = item.outside_temp >= item.inside_temp;
    assign out_le_in = item.outside_temp <= item.inside_temp;

    always_comb begin
        mode_next     = mode_reg;
        prev_ovr_next = prev_ovr_reg;
        flap_next     = flap_reg;
        vent_next     = vent_reg;
        peltier_next  = peltier_reg;
        fan_next      = fan_reg;
        pol_next      = pol_reg;
        relay_next    = relay_reg;

        if (ovr) begin
            if (!prev_ovr_reg) begin
                peltier_next  = '0;
                fan_next      = '0;
                relay_next    = 2'b00;
                vent_next     = 1'b0;
                mode_next     = MODE_IDLE;
                prev_ovr_next = 1'b1;
            end
        end else begin
            prev_ovr_next = 1'b0;
            case (mode_reg)
                MODE_HEAT: begin
                    if (in_ge_sp) begin
                        peltier_next = '0;
                        fan_next     = '0;
                        relay_next   = 2'b00;
                        mode_next    = MODE_IDLE;
                    end else if (item.outside_ok && out_gt_sp) begin
                        peltier_next = '0;
                        fan_next     = '0;
                        relay_next   = 2'b00;
                        flap_next    = 1'b1;
                        vent_next    = 1'b1;
                        mode_next    = MODE_FHEAT;
                    end
                end
                MODE_COOL: begin
                    if (in_le_sp) begin
                        peltier_next = '0;
                        fan_next     = '0;
                        relay_next   = 2'b00;
                        mode_next    = MODE_IDLE;
                    end else if (item.outside_ok && out_lt_sp) begin
                        peltier_next = '0;
                        fan_next     = '0;
                        relay_next   = 2'b00;
                        flap_next    = 1'b1;
                        vent_next    = 1'b1;
                        mode_next    = MODE_FCOOL;
                    end
                end
                MODE_FCOOL: begin
                    if (in_le_sp) begin
                        flap_next = 1'b0;
                        vent_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end else if (!item.outside_ok || out_ge_in) begin
                        flap_next    = 1'b0;
                        vent_next    = 1'b0;
                        pol_next     = 1'b0;
                        peltier_next = cfg.peltier_level;
                        fan_next     = cfg.fan_level;
                        relay_next   = 2'b10;
                        mode_next    = MODE_COOL;
                    end
                end
                MODE_FHEAT: begin
                    if (in_ge_sp) begin
                        flap_next = 1'b0;
                        vent_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end else if (!item.outside_ok || out_le_in) begin
                        flap_next    = 1'b0;
                        vent_next    = 1'b0;
                        pol_next     = 1'b1;
                        peltier_next = cfg.peltier_level;
                        fan_next     = cfg.fan_level;
                        relay_next   = 2'b01;
                        mode_next    = MODE_HEAT;
                    end
                end
                default: begin
                    // Idle, and any stray code behaves as idle.
                    if (inside_w <= band_lo) begin
                        if (item.outside_ok && out_gt_sp) begin
                            flap_next = 1'b1;
                            vent_next = 1'b1;
                            mode_next = MODE_FHEAT;
                        end else begin
                            pol_next     = 1'b1;
                            peltier_next = cfg.peltier_level;
                            fan_next     = cfg.fan_level;
                            relay_next   = 2'b01;
                            mode_next    = MODE_HEAT;
                        end
                    end else if (inside_w >= band_hi) begin
                        if (item.outside_ok && out_lt_sp) begin
                            flap_next = 1'b1;
                            vent_next = 1'b1;
                            mode_next = MODE_FCOOL;
                        end else begin
                            pol_next     = 1'b0;
                            peltier_next = cfg.peltier_level;
                            fan_next     = cfg.fan_level;
                            relay_next   = 2'b10;
                            mode_next    = MODE_COOL;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            prev_ovr_reg <= 1'b0;
            flap_reg     <= 1'b0;
            vent_reg     <= 1'b0;
            peltier_reg  <= '0;
            fan_reg      <= '0;
            pol_reg      <= 1'b0;
            relay_reg    <= 2'b00;
        end else if (advance) begin
            mode_reg     <= mode_next;
            prev_ovr_reg <= prev_ovr_next;
            flap_reg     <= flap_next;
            vent_reg     <= vent_next;
            peltier_reg  <= peltier_next;
            fan_reg      <= fan_next;
            pol_reg      <= pol_next;
            relay_reg    <= relay_next;
        end
    end

    always_comb begin
        result.mode             = mode_next;
        result.peltier_duty     = peltier_next;
        result.fan_duty         = fan_next;
        result.heat_polarity    = pol_next;
        result.heat_relay_on    = relay_next[0];
        result.cool_relay_on    = relay_next[1];
        result.flap_is_open     = flap_next;
        result.free_vent_active = vent_next;
        result.override_active  = ovr;
    end

endmodule

`default_nettype wire

>>> hw/rtl/thermostat_free_venting_fsm.sv
// Five-mode thermostat with outside-air economizer. Each transfer on the s_
// channel is one evaluation tick (inside and outside temperature in signed
// tenths of a degree, outside sensor health, two venting overrides) and yields
// exactly one transfer on the m_ channel with the mode and actuator commands
// after that tick. The block sustains one tick per clock cycle while the
// consumer keeps m_ready high; each tick passes through the input register
// and then the result register, around the combinational mode update.
// Setpoint,
// hysteresis and the start duties are written through the cfg_ port, which
// is always ready; write it only while no tick is in flight. Reset restores
// setpoint 22.0, hysteresis 0.5, full duties and idle with all drives off.
`default_nettype none

module thermostat_free_venting_fsm (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire tfv_pkg::tfv_in_t                    s_data,

    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output tfv_pkg::tfv_out_t                        m_data,

    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [tfv_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  wire logic [tfv_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import tfv_pkg::*;

    tfv_cfg_t cfg;
    tfv_out_t result;

    // Input stage: hold one tick until the result register can take it.
    logic     in_valid_reg;
    tfv_in_t  in_data_reg;
    // Result stage: hold one result until the consumer takes it.
    logic     out_valid_reg;
    tfv_out_t out_data_reg;

    logic advance;
    logic s_xfer;

    // Advance the input stage whenever the result slot is free or drains now.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    assign cfg_ready = 1'b1;

    tfv_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tfv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (in_data_reg),
        .cfg      (cfg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Capture payload only on a transfer; it needs no reset.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
